>>> rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants of the lru key-value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  // port widths fixed by the word format
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned KEY_PORT_W   = 64;
  localparam int unsigned VALUE_PORT_W = 32;
  localparam int unsigned COUNT_PORT_W = 5;
  localparam int unsigned CAP_W        = 5;

  // default geometry
  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned KEY_WIDTH_DEF   = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // depth of the queue between front and back, a power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  // command codes on the input port
  localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // classified operation
  typedef enum logic [1:0] {
    OP_GET,
    OP_PUT,
    OP_CLEAR,
    OP_NOP
  } op_e;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic valid;
    op_e  op;
  } req_ctrl_t;

endpackage : lkvc_pkg

`default_nettype wire

>>> rtl/lkvc_front.sv
// ----------------------------------------------------------------------------
// lkvc_front
// accepts input words, decodes the command and buffers them in a short queue
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_front #(
  parameter int unsigned KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [lkvc_pkg::CMD_W-1:0]        cmd_i,
  input  wire logic [lkvc_pkg::KEY_PORT_W-1:0]   key_i,
  input  wire logic [lkvc_pkg::VALUE_PORT_W-1:0] write_value_i,
  output      lkvc_pkg::req_ctrl_t               req_o,
  output      logic [KEY_WIDTH-1:0]              req_key_o,
  output      logic [VALUE_WIDTH-1:0]            req_value_o,
  input  wire logic                              pop_i
);
  import lkvc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_e                    op_q  [QUEUE_DEPTH];
  logic [KEY_WIDTH-1:0]   key_q [QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0] val_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]       cnt_q;
  op_e                    op_dec;
  logic                   push, pop;

  // command decode
  always_comb begin
    unique case (cmd_i)
      CMD_GET:   op_dec = OP_GET;
      CMD_PUT:   op_dec = OP_PUT;
      CMD_CLEAR: op_dec = OP_CLEAR;
      CMD_NOP:   op_dec = OP_NOP;
      default:   op_dec = OP_NOP;
    endcase
  end

  assign in_stall_o = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]  <= op_dec;
      key_q[wr_ptr_q] <= KEY_WIDTH'(key_i);
      val_q[wr_ptr_q] <= VALUE_WIDTH'(write_value_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
      else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  assign req_o.valid = (cnt_q != '0);
  assign req_o.op    = op_q[rd_ptr_q];
  assign req_key_o   = key_q[rd_ptr_q];
  assign req_value_o = val_q[rd_ptr_q];

endmodule : lkvc_front

`default_nettype wire

>>> rtl/lkvc_back.sv
// ----------------------------------------------------------------------------
// lkvc_back
// tag match, recency ranks, value memory and result register
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_back #(
  parameter int unsigned DEPTH       = lkvc_pkg::DEPTH_DEF,
  parameter int unsigned KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire lkvc_pkg::req_ctrl_t               req_i,
  input  wire logic [KEY_WIDTH-1:0]              req_key_i,
  input  wire logic [VALUE_WIDTH-1:0]            req_value_i,
  output      logic                              pop_o,
  input  wire logic [lkvc_pkg::CAP_W-1:0]        capacity_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic                              hit_o,
  output      logic [lkvc_pkg::VALUE_PORT_W-1:0] read_value_o,
  output      logic [lkvc_pkg::COUNT_PORT_W-1:0] entry_count_o
);
  import lkvc_pkg::*;

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CCMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned VEXT_W = (VALUE_WIDTH > VALUE_PORT_W) ? VALUE_WIDTH : VALUE_PORT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_TOUCH,
    ACT_INSERT,
    ACT_CLEAR
  } act_e;

  state_e state_q;

  // cache state
  logic [DEPTH-1:0]       valid_q, valid_d;
  logic [IDX_W-1:0]       rank_q [DEPTH];
  logic [IDX_W-1:0]       rank_d [DEPTH];
  logic [CNT_W-1:0]       occ_q, occ_d;
  logic [KEY_WIDTH-1:0]   key_store [DEPTH];
  logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;

  // decision registered at lookup
  act_e                   act_q, act_d;
  logic                   hit_q, hit_d;
  logic                   rd_q, rd_d;
  logic                   wr_key_q, wr_key_d;
  logic                   wr_val_q, wr_val_d;
  logic [DEPTH-1:0]       tgt_oh_q, tgt_oh_d;
  logic [IDX_W-1:0]       tgt_idx_q, tgt_idx_d;
  logic [IDX_W-1:0]       tgt_rank_q, tgt_rank_d;
  logic [KEY_WIDTH-1:0]   key_lat_q;
  logic [VALUE_WIDTH-1:0] val_lat_q;

  // result register
  logic                    out_valid_q;
  logic                    hit_out_q;
  logic [VALUE_PORT_W-1:0] read_out_q;
  logic [COUNT_PORT_W-1:0] count_out_q;

  logic [DEPTH-1:0]  match, lru_oh, free_oh;
  logic              any_match, full;
  logic [CCMP_W-1:0] cap_ext, eff_cap;
  logic [VEXT_W-1:0] rdata_ext;
  logic              out_free;

  // parallel tag compare and victim search
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i]  = valid_q[i] && (key_store[i] == req_key_i);
      lru_oh[i] = valid_q[i] && (CNT_W'(rank_q[i]) == occ_q - CNT_W'(1));
    end
  end

  // lowest invalid entry
  assign free_oh   = ~valid_q & (valid_q + DEPTH'(1));
  assign any_match = |match;

  // capacity clamped to 1..DEPTH
  assign cap_ext = CCMP_W'(capacity_i);
  always_comb begin
    if (cap_ext == '0)                     eff_cap = CCMP_W'(1);
    else if (cap_ext > CCMP_W'(DEPTH))     eff_cap = CCMP_W'(DEPTH);
    else                                   eff_cap = cap_ext;
  end
  assign full = (CCMP_W'(occ_q) >= eff_cap);

  // classify the head item against the cache
  always_comb begin
    act_d    = ACT_NONE;
    hit_d    = 1'b0;
    rd_d     = 1'b0;
    wr_key_d = 1'b0;
    wr_val_d = 1'b0;
    tgt_oh_d = '0;
    if (req_i.valid) begin
      unique case (req_i.op)
        OP_GET: begin
          hit_d    = any_match;
          rd_d     = any_match;
          act_d    = any_match ? ACT_TOUCH : ACT_NONE;
          tgt_oh_d = match;
        end
        OP_PUT: begin
          hit_d    = any_match;
          wr_val_d = 1'b1;
          if (any_match) begin
            act_d    = ACT_TOUCH;
            tgt_oh_d = match;
          end else if (full) begin
            act_d    = ACT_TOUCH;
            wr_key_d = 1'b1;
            tgt_oh_d = lru_oh;
          end else begin
            act_d    = ACT_INSERT;
            wr_key_d = 1'b1;
            tgt_oh_d = free_oh;
          end
        end
        OP_CLEAR: act_d = ACT_CLEAR;
        OP_NOP:   act_d = ACT_NONE;
      endcase
    end
  end

  // one-hot to index and rank of the target
  always_comb begin
    tgt_idx_d  = '0;
    tgt_rank_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tgt_idx_d  = tgt_idx_d  | (tgt_oh_d[i] ? IDX_W'(i) : '0);
      tgt_rank_d = tgt_rank_d | (tgt_oh_d[i] ? rank_q[i] : '0);
    end
  end

  // recency and occupancy update
  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < DEPTH; i++) rank_d[i] = rank_q[i];
    if (state_q == S_EXEC) begin
      unique case (act_q)
        ACT_TOUCH: begin
          for (int i = 0; i < DEPTH; i++) begin
            if (tgt_oh_q[i])
              rank_d[i] = '0;
            else if (valid_q[i] && (rank_q[i] < tgt_rank_q))
              rank_d[i] = rank_q[i] + IDX_W'(1);
          end
        end
        ACT_INSERT: begin
          for (int i = 0; i < DEPTH; i++) begin
            if (tgt_oh_q[i])
              rank_d[i] = '0;
            else if (valid_q[i])
              rank_d[i] = rank_q[i] + IDX_W'(1);
          end
          valid_d = valid_q | tgt_oh_q;
          occ_d   = occ_q + CNT_W'(1);
        end
        ACT_CLEAR: begin
          for (int i = 0; i < DEPTH; i++) rank_d[i] = '0;
          valid_d = '0;
          occ_d   = '0;
        end
        ACT_NONE: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < DEPTH; i++) rank_q[i] <= '0;
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < DEPTH; i++) rank_q[i] <= rank_d[i];
    end
  end

  // key store
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC && wr_key_q) key_store[tgt_idx_q] <= key_lat_q;
  end

  // value memory, one port, registered read
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      if (wr_val_q)  value_mem[tgt_idx_q] <= val_lat_q;
      else if (rd_q) rdata_q <= value_mem[tgt_idx_q];
    end
  end

  assign rdata_ext = VEXT_W'(rdata_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign pop_o     = (state_q == S_IDLE) && req_i.valid;

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_NONE;
      hit_q       <= 1'b0;
      rd_q        <= 1'b0;
      wr_key_q    <= 1'b0;
      wr_val_q    <= 1'b0;
      tgt_oh_q    <= '0;
      tgt_idx_q   <= '0;
      tgt_rank_q  <= '0;
      key_lat_q   <= '0;
      val_lat_q   <= '0;
      out_valid_q <= 1'b0;
      hit_out_q   <= 1'b0;
      read_out_q  <= '0;
      count_out_q <= '0;
    end else begin
      if (state_q == S_RESP && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            act_q      <= act_d;
            hit_q      <= hit_d;
            rd_q       <= rd_d;
            wr_key_q   <= wr_key_d;
            wr_val_q   <= wr_val_d;
            tgt_oh_q   <= tgt_oh_d;
            tgt_idx_q  <= tgt_idx_d;
            tgt_rank_q <= tgt_rank_d;
            key_lat_q  <= req_key_i;
            val_lat_q  <= req_value_i;
            state_q    <= S_EXEC;
          end
        end
        S_EXEC: state_q <= S_RESP;
        S_RESP: begin
          if (out_free) begin
            hit_out_q   <= hit_q;
            read_out_q  <= rd_q ? rdata_ext[VALUE_PORT_W-1:0] : '0;
            count_out_q <= COUNT_PORT_W'(occ_q);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_out_q;
  assign read_value_o  = read_out_q;
  assign entry_count_o = count_out_q;

  // occupancy tracks the valid bits
  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy out of step with valid bits");

  // a touch or insert names exactly one entry
  a_tgt_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && (act_q == ACT_TOUCH || act_q == ACT_INSERT)) |-> $onehot(tgt_oh_q))
    else $error("update target not one-hot");

  // insert only into a free entry
  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && act_q == ACT_INSERT) |-> ((tgt_oh_q & valid_q) == '0))
    else $error("insert over a valid entry");

  // after a clear the reported count is zero
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && act_q == ACT_CLEAR) |-> (occ_q == '0))
    else $error("clear left entries behind");

endmodule : lkvc_back

`default_nettype wire

>>> rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake                word contents
//   -------  ---  -----------------------  ---------------------------------
//   cfg      in   cfg_we_i                 cfg_wdata_i (capacity)
//   in       in   in_valid_i / in_stall_o  cmd_i, key_i, write_value_i
//   out      out  out_valid_o / out_stall_i  hit_o, read_value_o, entry_count_o
//
// - each word passes the back end in order through lookup, update and respond,
//   set by the single-port value memory and the rank update after lookup
// - a two-word queue lets the front keep accepting while the back end works
// - the result register frees the back end as soon as the previous result is taken
// - reset empties the cache and sets capacity to sixteen, no clearing pass
// - a stalled result holds, and the back end waits in its respond step
//
`default_nettype none

module lru_key_value_cache_unit #(
  parameter int unsigned DEPTH       = lkvc_pkg::DEPTH_DEF,
  parameter int unsigned KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // capacity register
  input  wire logic                              cfg_we_i,
  input  wire logic [lkvc_pkg::CAP_W-1:0]        cfg_wdata_i,
  // request channel
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [lkvc_pkg::CMD_W-1:0]        cmd_i,
  input  wire logic [lkvc_pkg::KEY_PORT_W-1:0]   key_i,
  input  wire logic [lkvc_pkg::VALUE_PORT_W-1:0] write_value_i,
  // result channel
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic                              hit_o,
  output      logic [lkvc_pkg::VALUE_PORT_W-1:0] read_value_o,
  output      logic [lkvc_pkg::COUNT_PORT_W-1:0] entry_count_o
);
  import lkvc_pkg::*;

  // capacity, to be changed by the user only while the cache is idle and empty; the block does not enforce it
  logic [CAP_W-1:0] capacity_q;

  // head of the queue towards the back end
  req_ctrl_t              req;
  logic [KEY_WIDTH-1:0]   req_key;
  logic [VALUE_WIDTH-1:0] req_value;
  logic                   pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // front: decode the command, trim key and value, queue the word
  lkvc_front #(
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .write_value_i (write_value_i),
    .req_o         (req),
    .req_key_o     (req_key),
    .req_value_o   (req_value),
    .pop_i         (pop)
  );

  // back: tag match, lru bookkeeping, value memory, result register
  lkvc_back #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .req_key_i     (req_key),
    .req_value_i   (req_value),
    .pop_o         (pop),
    .capacity_i    (capacity_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o)
  );

endmodule : lru_key_value_cache_unit

`default_nettype wire

>>> dv/tb_lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit
// self-checking testbench of the lru key-value cache
// ----------------------------------------------------------------------------
// A behavioural copy of the cache in a small scoreboard class works out each
// response from every request word taken by the unit. Responses are checked
// in order, field by field. A directed burst covers the edge keys and values,
// every command, capacity clamping and capacity changes with entries held.
// Random phases then run with various capacities and idle patterns on both
// channels, including a long result hold-off and a full drain mid-phase.
// ----------------------------------------------------------------------------

module tb_lru_key_value_cache_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int unsigned SLOTS       = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned POOL_MAX    = 32;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic                    hit;
    logic [VALUE_PORT_W-1:0] read_value;
    logic [COUNT_PORT_W-1:0] entry_count;
  } cache_response_t;

  // behavioural cache and the queue of responses still owed by the unit
  class lru_cache_scoreboard;
    logic [KEY_PORT_W-1:0]   key_mem [SLOTS];
    logic [VALUE_PORT_W-1:0] val_mem [SLOTS];
    bit                      live    [SLOTS];
    int unsigned             rank    [SLOTS];
    int unsigned             count;
    logic [CAP_W-1:0]        capacity;
    cache_response_t         pending_responses [$];
    int unsigned             mismatch_count;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        key_mem[i] = '0;
        val_mem[i] = '0;
        live[i]    = 1'b0;
        rank[i]    = 0;
      end
      count          = 0;
      capacity       = CAP_RESET;
      mismatch_count = 0;
    endfunction

    function void set_capacity(input logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    // register clamped to 1..SLOTS
    function int unsigned usable_slots();
      int unsigned c;
      c = capacity;
      if (c < 1) c = 1;
      if (c > SLOTS) c = SLOTS;
      return c;
    endfunction

    function int find_slot(input logic [KEY_PORT_W-1:0] key);
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && key_mem[i] == key) return i;
      return -1;
    endfunction

    // make slot e most recent, younger entries age by one
    function void promote(input int e);
      int unsigned r;
      r = rank[e];
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && i != e && rank[i] < r) rank[i]++;
      rank[e] = 0;
    endfunction

    function void note_request(input logic [CMD_W-1:0] cmd, input logic [KEY_PORT_W-1:0] key,
                               input logic [VALUE_PORT_W-1:0] wval);
      cache_response_t r;
      int              slot;
      int              oldest;
      r.hit        = 1'b0;
      r.read_value = '0;
      case (cmd)
        CMD_GET: begin
          slot = find_slot(key);
          if (slot >= 0) begin
            r.hit        = 1'b1;
            r.read_value = val_mem[slot];
            promote(slot);
          end
        end
        CMD_PUT: begin
          slot = find_slot(key);
          if (slot >= 0) begin
            r.hit         = 1'b1;
            val_mem[slot] = wval;
            promote(slot);
          end else if (count >= usable_slots()) begin
            // full, or capacity lowered below occupancy: replace in place
            oldest = -1;
            for (int i = 0; i < SLOTS; i++)
              if (live[i] && (oldest < 0 || rank[i] > rank[oldest])) oldest = i;
            if (oldest >= 0) begin
              key_mem[oldest] = key;
              val_mem[oldest] = wval;
              promote(oldest);
            end
          end else begin
            slot = -1;
            for (int i = 0; i < SLOTS; i++)
              if (!live[i] && slot < 0) slot = i;
            if (slot >= 0) begin
              for (int i = 0; i < SLOTS; i++)
                if (live[i]) rank[i]++;
              key_mem[slot] = key;
              val_mem[slot] = wval;
              live[slot]    = 1'b1;
              rank[slot]    = 0;
              count++;
            end
          end
        end
        CMD_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) begin
            live[i] = 1'b0;
            rank[i] = 0;
          end
          count = 0;
        end
        default: ;
      endcase
      r.entry_count = COUNT_PORT_W'(count);
      pending_responses = {pending_responses, r};
    endfunction

    function void check_response(input logic hit, input logic [VALUE_PORT_W-1:0] rd,
                                 input logic [COUNT_PORT_W-1:0] cnt);
      cache_response_t want;
      if (pending_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("ERROR: unexpected response hit %0b value %h count %0d", hit, rd, cnt);
        return;
      end
      want = pending_responses.pop_front();
      if (want.hit !== hit || want.read_value !== rd || want.entry_count !== cnt) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("ERROR: expected hit %0b value %h count %0d, got hit %0b value %h count %0d",
                   want.hit, want.read_value, want.entry_count, hit, rd, cnt);
      end
    endfunction
  endclass

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata_i   = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic [CMD_W-1:0]        cmd_i         = CMD_GET;
  logic [KEY_PORT_W-1:0]   key_i         = '0;
  logic [VALUE_PORT_W-1:0] write_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic                    hit_o;
  logic [VALUE_PORT_W-1:0] read_value_o;
  logic [COUNT_PORT_W-1:0] entry_count_o;

  lru_key_value_cache_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .write_value_i (write_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o)
  );

  lru_cache_scoreboard sb = new();

  // idle pressure on both channels, in cycles per hundred
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  // long result hold-off, asked for by the stimulus and counted below
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;

  // key pool for the current phase, small so that hits and evictions occur
  logic [KEY_PORT_W-1:0] key_pool [POOL_MAX];
  int unsigned           pool_size = 1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: random stall, or a long hold-off once asked for
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // both handshakes sampled at the rising edge, request noted before response
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(cmd_i, key_i, write_value_i);
      if (out_valid_o && !out_stall_i) sb.check_response(hit_o, read_value_o, entry_count_o);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned g;
    g = 0;
    while ($urandom_range(99) < tx_idle_pct && g < 40) g++;
    return g;
  endfunction

  // offer one request word and hold it until taken
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [KEY_PORT_W-1:0] k,
                           input logic [VALUE_PORT_W-1:0] v);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    key_i         <= k;
    write_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering and wait for every owed response
  task automatic drain_responses();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_responses.size() != 0) @(posedge clk_i);
  endtask

  // capacity only changes while nothing is in flight
  task automatic write_capacity(input logic [CAP_W-1:0] c);
    drain_responses();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_capacity(c);
  endtask

  function automatic logic [KEY_PORT_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  task automatic build_pool(input logic [CAP_W-1:0] cap);
    int unsigned eff;
    eff = (cap < 1) ? 1 : ((cap > SLOTS) ? SLOTS : cap);
    pool_size = eff + $urandom_range(1, 6);
    if (pool_size > POOL_MAX) pool_size = POOL_MAX;
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = random_key();
    // keep the edge keys in play
    key_pool[0] = '0;
    key_pool[1] = '1;
  endtask

  task automatic run_phase(input int unsigned n_words, input int unsigned tx_pct,
                           input int unsigned rx_pct, input logic [CAP_W-1:0] cap,
                           input int hold_at, input int pause_at);
    int unsigned           roll;
    logic [CMD_W-1:0]      c;
    logic [KEY_PORT_W-1:0] k;
    write_capacity(cap);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    build_pool(cap);
    for (int i = 0; i < n_words; i++) begin
      if (i == hold_at) hold_request = 90;
      if (i == pause_at) drain_responses();
      roll = $urandom_range(99);
      if (roll < 45)      c = CMD_GET;
      else if (roll < 94) c = CMD_PUT;
      else if (roll < 97) c = CMD_CLEAR;
      else                c = CMD_NOP;
      // mostly keys from the pool, now and then a fresh one
      if ($urandom_range(99) < 88) k = key_pool[$urandom_range(pool_size - 1)];
      else                         k = random_key();
      send_word(c, k, $urandom);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed burst, reset capacity of sixteen
    send_word(CMD_GET,   64'h0, 32'hffff_ffff);           // miss on empty
    send_word(CMD_PUT,   64'h0, 32'h0);
    send_word(CMD_PUT,   '1, '1);
    send_word(CMD_PUT,   64'h7fff_ffff_ffff_ffff, 32'h8000_0000);
    send_word(CMD_GET,   '1, 32'h0);
    send_word(CMD_GET,   64'h0, 32'h1234_5678);
    send_word(CMD_GET,   64'h7fff_ffff_ffff_ffff, 32'h0);
    send_word(CMD_PUT,   64'h0, 32'ha5a5_a5a5);           // overwrite present key
    send_word(CMD_GET,   64'h0, 32'h0);
    send_word(CMD_NOP,   64'h8000_0000_0000_0001, '1);    // unused command
    send_word(CMD_CLEAR, '1, '1);
    send_word(CMD_GET,   '1, 32'h0);                      // miss after clear

    // zero capacity behaves as one
    write_capacity(5'd0);
    send_word(CMD_PUT, 64'h1111, 32'h1);
    send_word(CMD_PUT, 64'h2222, 32'h2);                  // evicts the first
    send_word(CMD_GET, 64'h1111, 32'h0);
    send_word(CMD_GET, 64'h2222, 32'h0);

    // capacity three, recency decides the victim
    write_capacity(5'd3);
    send_word(CMD_PUT, 64'h3333, 32'h3);
    send_word(CMD_PUT, 64'h4444, 32'h4);
    send_word(CMD_GET, 64'h2222, 32'h0);
    send_word(CMD_PUT, 64'h5555, 32'h5);                  // 3333 is oldest
    send_word(CMD_GET, 64'h3333, 32'h0);

    // capacity lowered with three entries held: replace in place
    write_capacity(5'd1);
    send_word(CMD_PUT, 64'h6666, 32'h6);
    send_word(CMD_GET, 64'h6666, 32'h0);

    // random phases: capacity, idle pattern, hold-off and pause points
    run_phase(230, 0,  0,  5'd16, 60, -1);
    run_phase(230, 55, 0,  5'd4,  -1, 120);
    run_phase(230, 0,  55, 5'd1,  -1, -1);
    run_phase(230, 30, 30, 5'd31, -1, -1);
    run_phase(230, 0,  0,  5'($urandom_range(2, 15)), -1, -1);
    run_phase(230, 55, 0,  5'd0,  -1, 100);
    run_phase(230, 0,  55, 5'd8,  40, -1);
    run_phase(230, 30, 30, 5'($urandom), -1, -1);

    drain_responses();
    repeat (20) @(posedge clk_i);

    if (sb.mismatch_count == 0 && sb.pending_responses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
